@@ rtl/core/spr_pkg.sv @@
package spr_pkg;

  localparam int PAT_W      = 256;
  localparam int PIDX_W     = 5;
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int RND_W      = 31;
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = 2;

  localparam logic KIND_LIT  = 1'b0;
  localparam logic KIND_MARK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_31 = 3'd3,
    REG_PAT_LEN   = 3'd4,
    REG_ONCE      = 3'd5,
    REG_REUSE     = 3'd6
  } cfg_reg_t;

  // What the back end emits after the optional release of held bytes
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_LIT  = 2'd1,
    TAIL_MARK = 2'd2
  } tail_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             end_of_stream;
    logic [RND_W-1:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic             item_kind;
    logic [7:0]       out_byte;
    logic [RND_W-1:0] number_value;
    logic             run_last;
    logic             stream_done;
  } out_item_t;

  typedef struct packed {
    logic             release_held;
    logic             hold;
    tail_t            tail;
    logic             eos;
    logic [7:0]       raw;
    logic [RND_W-1:0] value;
  } cmd_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] p,
                                          input logic [PIDX_W-1:0] i);
    return p[{i, 3'b000} +: 8];
  endfunction

endpackage

@@ rtl/core/spr_front.sv @@
module spr_front #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            accept,
  input  spr_pkg::in_item_t               item,
  output spr_pkg::cmd_t                   cmd
);
  import spr_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  logic [PAT_W-1:0]  pat_r;
  logic [LEN_W-1:0]  len_r;
  logic              once_r;
  logic              reuse_r;

  logic [CNT_W-1:0]  progress_r;
  logic              replaced_r;
  logic              cached_valid_r;
  logic [RND_W-1:0]  cached_r;

  logic [7:0]        ch;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  prog_ext;
  logic [LEN_W-1:0]  prog_eff;
  logic [LEN_W-1:0]  prog_inc;
  logic [LEN_W-1:0]  prog_nxt;
  logic              disabled;
  logic              cont;
  logic              start;
  logic              mark;
  logic [RND_W-1:0]  value_sel;
  cmd_t              cmd_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= '0;
      len_r   <= '0;
      once_r  <= 1'b1;
      reuse_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PAT_0_7:   pat_r[63:0]    <= cfg_data;
        REG_PAT_8_15:  pat_r[127:64]  <= cfg_data;
        REG_PAT_16_23: pat_r[191:128] <= cfg_data;
        REG_PAT_24_31: pat_r[255:192] <= cfg_data;
        REG_PAT_LEN:   len_r          <= cfg_data[LEN_W-1:0];
        REG_ONCE:      once_r         <= cfg_data[0];
        REG_REUSE:     reuse_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ch       = to_lower(item.data_byte);
    len_eff  = (len_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_r;
    prog_ext = LEN_W'(progress_r);
    // a shortened pattern drops the open match
    prog_eff = (prog_ext >= len_eff) ? '0 : prog_ext;
    prog_inc = prog_eff + 1'b1;
    disabled = (len_eff == '0) || (once_r && replaced_r);
    cont     = (prog_eff != '0) && (ch == pat_byte(pat_r, PIDX_W'(prog_eff)));
    start    = (ch == pat_byte(pat_r, '0));

    cmd_c              = '0;
    cmd_c.release_held = 1'b1;
    cmd_c.tail         = TAIL_LIT;
    cmd_c.eos          = item.end_of_stream;
    cmd_c.raw          = item.data_byte;
    prog_nxt           = '0;

    if (!disabled) begin
      if (cont) begin
        cmd_c.release_held = 1'b0;
        if (prog_inc == len_eff) begin
          cmd_c.tail = TAIL_MARK;
        end else begin
          cmd_c.hold = 1'b1;
          cmd_c.tail = TAIL_NONE;
          prog_nxt   = prog_inc;
        end
      end else if (start) begin
        if (len_eff == LEN_W'(1)) begin
          cmd_c.tail = TAIL_MARK;
        end else begin
          cmd_c.hold = 1'b1;
          cmd_c.tail = TAIL_NONE;
          prog_nxt   = LEN_W'(1);
        end
      end
    end

    // end of stream: flush everything held, the new byte last
    if (item.end_of_stream && cmd_c.hold) begin
      cmd_c.release_held = 1'b1;
      cmd_c.hold         = 1'b0;
      cmd_c.tail         = TAIL_LIT;
    end

    mark      = (cmd_c.tail == TAIL_MARK);
    value_sel = (reuse_r && cached_valid_r) ? cached_r : item.random_value;
    cmd_c.value = mark ? value_sel : '0;
  end

  assign cmd = cmd_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      progress_r     <= '0;
      replaced_r     <= 1'b0;
      cached_valid_r <= 1'b0;
      cached_r       <= '0;
    end else if (accept) begin
      if (item.end_of_stream) begin
        progress_r     <= '0;
        replaced_r     <= 1'b0;
        cached_valid_r <= 1'b0;
        cached_r       <= '0;
      end else begin
        progress_r <= CNT_W'(prog_nxt);
        if (mark && once_r) begin
          replaced_r <= 1'b1;
        end
        if (mark && reuse_r && !cached_valid_r) begin
          cached_valid_r <= 1'b1;
          cached_r       <= item.random_value;
        end
      end
    end
  end

endmodule

@@ rtl/core/spr_cmd_fifo.sv @@
module spr_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  spr_pkg::cmd_t  wr_data,
  output logic           full,
  input  logic           rd_en,
  output spr_pkg::cmd_t  rd_data,
  output logic           rd_valid
);
  import spr_pkg::*;

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r;
  logic [CMD_PTR_W-1:0] rd_ptr_r;
  logic [CMD_PTR_W:0]   count_r;
  logic                 do_wr;
  logic                 do_rd;

  assign full     = (count_r == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign rd_valid = (count_r != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/spr_back.sv @@
module spr_back #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  spr_pkg::cmd_t        cmd,
  output logic                 cmd_pop,
  output logic                 empty,
  input  logic                 pop,
  output spr_pkg::out_item_t   out_data
);
  import spr_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [7:0]       held_r [MAX_PATTERN];
  logic [CNT_W-1:0] held_cnt_r;
  logic [CNT_W-1:0] held_cnt_nxt;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] idx_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_r;
  out_item_t        out_nxt;

  logic             adv;
  logic             in_rel;
  logic             rel_last;
  logic             emit;
  logic             done;
  logic [IDX_W-1:0] wr_addr;

  always_comb begin
    adv      = cmd_valid && (!out_valid_r || pop);
    in_rel   = cmd.release_held && (idx_r < held_cnt_r);
    rel_last = ((idx_r + 1'b1) == held_cnt_r) && (cmd.tail == TAIL_NONE);
    emit     = in_rel || (cmd.tail != TAIL_NONE);
    done     = in_rel ? rel_last : 1'b1;
    cmd_pop  = adv && done;

    out_nxt = '0;
    if (in_rel) begin
      out_nxt.item_kind   = KIND_LIT;
      out_nxt.out_byte    = held_r[idx_r[IDX_W-1:0]];
      out_nxt.run_last    = rel_last;
      out_nxt.stream_done = rel_last && cmd.eos;
    end else begin
      out_nxt.item_kind   = (cmd.tail == TAIL_MARK) ? KIND_MARK : KIND_LIT;
      out_nxt.out_byte    = (cmd.tail == TAIL_LIT) ? cmd.raw : 8'h00;
      out_nxt.number_value = (cmd.tail == TAIL_MARK) ? cmd.value : '0;
      out_nxt.run_last    = 1'b1;
      out_nxt.stream_done = cmd.eos;
    end

    if (adv && emit) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    idx_nxt = idx_r;
    if (adv) begin
      idx_nxt = done ? '0 : idx_r + 1'b1;
    end

    // a new partial match starts over at entry zero after a release
    wr_addr      = cmd.release_held ? '0 : held_cnt_r[IDX_W-1:0];
    held_cnt_nxt = held_cnt_r;
    if (cmd_pop) begin
      if (cmd.hold) begin
        held_cnt_nxt = cmd.release_held ? CNT_W'(1) : held_cnt_r + 1'b1;
      end else begin
        held_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.hold) begin
      held_r[wr_addr] <= cmd.raw;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r  <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_cnt_r  <= held_cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

endmodule

@@ rtl/core/stream_pattern_replace_top.sv @@
// Streaming find-and-replace over a byte stream.
// Input side is a queue: drive in_data and raise push; the beat is taken
// when full is low. Result side is a queue too: a result beat sits on
// out_data while empty is low and leaves at a clock edge with pop high.
// Each input byte is lower-cased and matched against a pattern of up to
// MAX_PATTERN bytes; bytes of an open partial match are held back and are
// released as literals on a mismatch, at end of stream, or when matching is
// switched off. A full match becomes one number marker beat.
// The configuration port writes one register per cycle with cfg_we high;
// write it only while the block is idle.
// Each taken byte's command goes into a four-entry command queue, and its
// results leave through the back end's output register, one result beat per
// cycle while the receiver pops; a byte yields up to MAX_PATTERN results on a
// release, and the queue lets input run ahead meanwhile.
// When the receiver stalls, the output register holds its beat, the queue
// fills and full rises. Reset restores the register defaults, empties the
// queue and clears all stream state; the held-byte store is not cleared.
module stream_pattern_replace_top #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  spr_pkg::in_item_t               in_data,
  output logic                            empty,
  input  logic                            pop,
  output spr_pkg::out_item_t              out_data
);
  import spr_pkg::*;

  logic accept;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic head_valid;
  logic head_pop;

  assign accept = push && !full;

  spr_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (in_data),
    .cmd       (front_cmd)
  );

  spr_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_data  (front_cmd),
    .full     (full),
    .rd_en    (head_pop),
    .rd_data  (head_cmd),
    .rd_valid (head_valid)
  );

  spr_back #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (head_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_reset_clears : assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  a_done_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.stream_done) |-> out_data.run_last)
    else $error("stream_done on a beat that is not the last of its byte");

  a_marker_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.item_kind == KIND_MARK) |-> (out_data.out_byte == 8'h00))
    else $error("marker beat carries a byte");

  a_literal_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.item_kind == KIND_LIT) |-> (out_data.number_value == '0))
    else $error("literal beat carries a number");
`endif

endmodule

@@ verif/tb_stream_pattern_replace_top.sv @@
`timescale 1ns / 1ps

module tb_stream_pattern_replace_top;
  import spr_pkg::*;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  cfg_reg_t  cfg_index = REG_PAT_0_7;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic      push      = 1'b0;
  in_item_t  in_data   = '0;
  logic      pop       = 1'b0;
  logic      full;
  logic      empty;
  out_item_t out_data;

  stream_pattern_replace_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Pattern matcher mirror: configuration and per-stream state
  logic [PAT_W-1:0] pat_bits;
  logic [LEN_W-1:0] pat_len;
  logic             once_on;
  logic             reuse_on;
  int               progress;
  logic [7:0]       held [32];
  logic             replaced;
  logic             cached_ok;
  logic [RND_W-1:0] cached_num;

  out_item_t step_res[$];
  out_item_t want_q[$];
  in_item_t  pend_q[$];

  int   fail_cnt   = 0;
  int   queued_cnt = 0;
  int   taken_cnt  = 0;
  logic quiet      = 1'b0;
  logic rand_phase = 1'b0;

  function automatic logic [7:0] pattern_byte(int i);
    return pat_bits[i*8 +: 8];
  endfunction

  task automatic emit(logic kind, logic [7:0] b, logic [RND_W-1:0] v);
    out_item_t r;
    r = '0;
    r.item_kind    = kind;
    r.out_byte     = b;
    r.number_value = v;
    step_res.push_back(r);
  endtask

  task automatic flush_held();
    for (int i = 0; i < progress; i++) emit(KIND_LIT, held[i], '0);
    progress = 0;
  endtask

  task automatic emit_marker(logic [RND_W-1:0] rnd);
    logic [RND_W-1:0] v;
    v = rnd;
    if (reuse_on) begin
      if (!cached_ok) begin
        cached_num = rnd;
        cached_ok  = 1'b1;
      end
      v = cached_num;
    end
    emit(KIND_MARK, 8'h00, v);
    if (once_on) replaced = 1'b1;
  endtask

  task automatic predict_item(in_item_t it);
    logic [7:0] ch;
    int         len;
    out_item_t  r;
    step_res.delete();
    ch = it.data_byte;
    if (ch >= 8'h41 && ch <= 8'h5a) ch = ch + 8'h20;
    len = (pat_len > 32) ? 32 : int'(pat_len);
    if (len == 0 || (once_on && replaced)) begin
      flush_held();
      emit(KIND_LIT, it.data_byte, '0);
    end else begin
      // length lowered under an open match
      if (progress >= len) flush_held();
      if (progress > 0 && ch == pattern_byte(progress)) begin
        held[progress] = it.data_byte;
        progress++;
        if (progress == len) begin
          progress = 0;
          emit_marker(it.random_value);
        end
      end else begin
        flush_held();
        if (ch == pattern_byte(0)) begin
          if (len == 1) begin
            emit_marker(it.random_value);
          end else begin
            held[0]  = it.data_byte;
            progress = 1;
          end
        end else begin
          emit(KIND_LIT, it.data_byte, '0);
        end
      end
    end
    if (it.end_of_stream) begin
      flush_held();
      replaced   = 1'b0;
      cached_ok  = 1'b0;
      cached_num = '0;
    end
    foreach (step_res[i]) begin
      r = step_res[i];
      if (i == step_res.size() - 1) begin
        r.run_last    = 1'b1;
        r.stream_done = it.end_of_stream;
      end
      want_q.push_back(r);
    end
  endtask

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (want_q.size() == 0) begin
      $display("%0t: unexpected beat kind %0d byte %h value %0d last %0d done %0d",
               $time, got.item_kind, got.out_byte, got.number_value, got.run_last,
               got.stream_done);
      fail_cnt++;
    end else begin
      want = want_q.pop_front();
      report_field("item_kind", want.item_kind, got.item_kind);
      report_field("out_byte", want.out_byte, got.out_byte);
      report_field("number_value", want.number_value, got.number_value);
      report_field("run_last", want.run_last, got.run_last);
      report_field("stream_done", want.stream_done, got.stream_done);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pat_bits   = '0;
      pat_len    = '0;
      once_on    = 1'b1;
      reuse_on   = 1'b0;
      progress   = 0;
      replaced   = 1'b0;
      cached_ok  = 1'b0;
      cached_num = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PAT_0_7:   pat_bits[63:0]    = cfg_data;
          REG_PAT_8_15:  pat_bits[127:64]  = cfg_data;
          REG_PAT_16_23: pat_bits[191:128] = cfg_data;
          REG_PAT_24_31: pat_bits[255:192] = cfg_data;
          REG_PAT_LEN:   pat_len           = cfg_data[LEN_W-1:0];
          REG_ONCE:      once_on           = cfg_data[0];
          REG_REUSE:     reuse_on          = cfg_data[0];
          default: ;
        endcase
      end
      if (push && !full) begin
        predict_item(in_data);
        taken_cnt++;
      end
      if (pop && !empty) check_result(out_data);
    end
  end

  // Sender: hold each beat until taken, idle in bursts after some beats
  int send_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      push     <= 1'b0;
      send_gap <= 0;
    end else if (!push || !full) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        push     <= 1'b0;
      end else if (!quiet && push && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 11);
        push     <= 1'b0;
      end else if (pend_q.size() != 0) begin
        in_data <= pend_q.pop_front();
        push    <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back up the input
  int   pop_gap;
  int   long_left;
  logic long_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      pop       <= 1'b0;
      pop_gap   <= 0;
      long_left <= 0;
      long_done <= 1'b0;
    end else if (long_left > 0) begin
      long_left <= long_left - 1;
      pop       <= 1'b0;
    end else if (rand_phase && !long_done) begin
      long_done <= 1'b1;
      long_left <= 150;
      pop       <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      pop     <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      pop_gap <= $urandom_range(0, 11);
      pop     <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic queue_byte(logic [7:0] b, logic eos);
    in_item_t it;
    it.data_byte     = b;
    it.end_of_stream = eos;
    it.random_value  = RND_W'($urandom);
    pend_q.push_back(it);
    queued_cnt++;
  endtask

  function automatic logic [PAT_W-1:0] text_pattern(string s);
    logic [PAT_W-1:0] p;
    p = '0;
    for (int i = 0; i < s.len(); i++) p[i*8 +: 8] = s[i];
    return p;
  endfunction

  // Small alphabet so that partial matches and restarts are frequent
  function automatic logic [7:0] alpha_byte();
    return 8'h61 + 8'($urandom_range(0, 3));
  endfunction

  function automatic logic [7:0] mixed_case(logic [7:0] b);
    if (b >= 8'h61 && b <= 8'h7a && $urandom_range(0, 1) == 1) return b - 8'h20;
    return b;
  endfunction

  function automatic logic [PAT_W-1:0] random_pattern();
    logic [PAT_W-1:0] p;
    for (int i = 0; i < 32; i++) begin
      case ($urandom_range(0, 7))
        0:       p[i*8 +: 8] = 8'($urandom_range(0, 255));
        1:       p[i*8 +: 8] = 8'h30 + 8'($urandom_range(0, 9));
        default: p[i*8 +: 8] = alpha_byte();
      endcase
    end
    return p;
  endfunction

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return mixed_case(alpha_byte());
  endfunction

  // Mostly whole or broken pattern runs with random case, the rest noise
  task automatic queue_stream(int n, logic [PAT_W-1:0] pat, int len);
    int cnt;
    int seg;
    int k;
    cnt = 0;
    if (len > 32) len = 32;
    while (cnt < n) begin
      seg = $urandom_range(0, 9);
      if (len > 0 && seg < 5) k = len;
      else if (len > 1 && seg < 7) k = $urandom_range(1, len - 1);
      else k = 0;
      for (int i = 0; i < k; i++) begin
        queue_byte(mixed_case(pat[i*8 +: 8]), $urandom_range(0, 39) == 0);
        cnt++;
      end
      if (k == len && k != 0) begin
        if ($urandom_range(0, 7) == 0) queue_byte(noise_byte(), 1'b1);
      end else begin
        queue_byte(noise_byte(), $urandom_range(0, 19) == 0);
      end
      cnt++;
    end
  endtask

  // Wait for every beat to be taken and every result to drain
  task automatic settle();
    int guard;
    guard = 0;
    while ((taken_cnt != queued_cnt || want_q.size() != 0) && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_cfg(logic [PAT_W-1:0] pat, logic [CFG_DATA_W-1:0] len,
                             logic once, logic reuse);
    write_reg(REG_PAT_0_7, pat[63:0]);
    write_reg(REG_PAT_8_15, pat[127:64]);
    write_reg(REG_PAT_16_23, pat[191:128]);
    write_reg(REG_PAT_24_31, pat[255:192]);
    write_reg(REG_PAT_LEN, len);
    write_reg(REG_ONCE, CFG_DATA_W'(once));
    write_reg(REG_REUSE, CFG_DATA_W'(reuse));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [PAT_W-1:0] pat;
    logic [CFG_DATA_W-1:0] len_val;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: matching off, bytes pass
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    settle();

    // two-byte pattern, repeated matches sharing the first value
    program_cfg(text_pattern("ab"), 2, 1'b0, 1'b1);
    queue_byte("A", 1'b0);
    queue_byte("b", 1'b0);
    queue_byte("a", 1'b0);
    queue_byte("B", 1'b0);
    queue_byte("a", 1'b0);
    queue_byte("x", 1'b0);
    queue_byte("a", 1'b0);
    queue_byte("a", 1'b0);
    queue_byte("b", 1'b0);
    queue_byte("q", 1'b1);
    queue_byte("a", 1'b1);
    settle();

    // single byte pattern, replace once per stream
    program_cfg(text_pattern("z"), 1, 1'b1, 1'b0);
    queue_byte("Z", 1'b0);
    queue_byte("z", 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte("z", 1'b0);
    settle();

    // length saturates to 32; release the longest open match
    program_cfg({PAT_W{1'b1}}, {CFG_DATA_W{1'b1}}, 1'b0, 1'b0);
    repeat (31) queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    settle();

    // shrink the length, then disable, with a match open
    program_cfg(text_pattern("abcdef"), 6, 1'b0, 1'b0);
    queue_byte("a", 1'b0);
    queue_byte("b", 1'b0);
    queue_byte("c", 1'b0);
    queue_byte("d", 1'b0);
    settle();
    program_cfg(text_pattern("abcdef"), 3, 1'b0, 1'b0);
    queue_byte("x", 1'b0);
    queue_byte("a", 1'b0);
    queue_byte("b", 1'b0);
    queue_byte("C", 1'b0);
    queue_byte("a", 1'b0);
    queue_byte("b", 1'b0);
    settle();
    program_cfg(text_pattern("abcdef"), 0, 1'b0, 1'b0);
    queue_byte("Q", 1'b1);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) quiet = 1'b1;
      pat = random_pattern();
      case ($urandom_range(0, 9))
        0:       len_val = 0;
        1:       len_val = 1;
        2:       len_val = 32;
        3:       len_val = CFG_DATA_W'($urandom_range(33, 63));
        default: len_val = CFG_DATA_W'($urandom_range(2, 6));
      endcase
      program_cfg(pat, len_val, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      queue_stream(15, pat, int'(len_val[LEN_W-1:0]));
      rand_phase = 1'b1;
      settle();
    end

    if (want_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, want_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
